@@ hw/rtl/length_prefixed_frame_parser_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed frame parser
// Clocked, reset-gated concurrent assertion wrappers.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_PARSER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_MACROS_SVH

// Assert a property on the rising edge of clk, skipped while arst_n is low.
`define LPFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define LPFP_ASSERT_NEXT(lbl, ante, cons, msg) \
	`LPFP_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ hw/rtl/lpfp_pkg.sv @@
// ----------------------------------------------------------------------------
// lpfp_pkg
// Shared types and field widths of the length-prefixed frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package lpfp_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned TDATA_OUT_W = 40;

	// One parsed result
	typedef struct packed {
		logic [WORD_W-1:0] msg_id;
		logic [WORD_W-1:0] msg_len;
		logic [BYTE_W-1:0] data_byte;
		logic              empty_msg;
		logic              last;
	} result_t;

endpackage

`default_nettype wire

@@ hw/rtl/lpfp_deframer.sv @@
// ----------------------------------------------------------------------------
// lpfp_deframer
// Header/payload tracking, one stream byte per cycle while accept is high;
// emits that byte's result combinationally for the output register to capture.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfp_deframer (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             accept,
	input  wire logic [lpfp_pkg::BYTE_W-1:0]      rx_byte,
	input  wire logic                             flush,
	output logic                                  res_valid,
	output lpfp_pkg::result_t                     res
);
	import lpfp_pkg::*;

	localparam logic [1:0] HDR_ID_LO  = 2'd0;
	localparam logic [1:0] HDR_ID_HI  = 2'd1;
	localparam logic [1:0] HDR_LEN_LO = 2'd2;
	localparam logic [1:0] HDR_LEN_HI = 2'd3;

	logic              in_payload_q, in_payload_d;
	logic [1:0]        hdr_cnt_q, hdr_cnt_d;
	logic [WORD_W-1:0] cur_id_q, cur_id_d;
	logic [WORD_W-1:0] cur_len_q, cur_len_d;
	logic [WORD_W-1:0] left_q, left_d;
	logic [WORD_W-1:0] left_dec;
	logic [WORD_W-1:0] len_new;

	assign left_dec = left_q - WORD_W'(1);
	assign len_new  = {rx_byte, cur_len_q[BYTE_W-1:0]};

	// Next state and result of the accepted byte
	always_comb begin
		in_payload_d  = in_payload_q;
		hdr_cnt_d     = hdr_cnt_q;
		cur_id_d      = cur_id_q;
		cur_len_d     = cur_len_q;
		left_d        = left_q;
		res_valid     = 1'b0;
		res.msg_id    = cur_id_q;
		res.msg_len   = cur_len_q;
		res.data_byte = rx_byte;
		res.empty_msg = 1'b0;
		res.last      = 1'b0;
		if (accept) begin
			if (flush) begin
				in_payload_d = 1'b0;
				hdr_cnt_d    = HDR_ID_LO;
				cur_id_d     = '0;
				cur_len_d    = '0;
				left_d       = '0;
			end else if (in_payload_q) begin
				left_d    = left_dec;
				res_valid = 1'b1;
				res.last  = (left_dec == '0);
				if (left_dec == '0) begin
					in_payload_d = 1'b0;
				end
			end else begin
				unique case (hdr_cnt_q)
					HDR_ID_LO: begin
						cur_id_d  = {cur_id_q[WORD_W-1:BYTE_W], rx_byte};
						hdr_cnt_d = HDR_ID_HI;
					end
					HDR_ID_HI: begin
						cur_id_d  = {rx_byte, cur_id_q[BYTE_W-1:0]};
						hdr_cnt_d = HDR_LEN_LO;
					end
					HDR_LEN_LO: begin
						cur_len_d = {cur_len_q[WORD_W-1:BYTE_W], rx_byte};
						hdr_cnt_d = HDR_LEN_HI;
					end
					HDR_LEN_HI: begin
						cur_len_d = len_new;
						hdr_cnt_d = HDR_ID_LO;
						if (len_new == '0) begin
							// zero-length message: one empty, last result
							res_valid     = 1'b1;
							res.msg_len   = '0;
							res.data_byte = '0;
							res.empty_msg = 1'b1;
							res.last      = 1'b1;
						end else begin
							left_d       = len_new;
							in_payload_d = 1'b1;
						end
					end
					default: begin
						hdr_cnt_d = HDR_ID_LO;
					end
				endcase
			end
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			hdr_cnt_q    <= HDR_ID_LO;
			cur_id_q     <= '0;
			cur_len_q    <= '0;
			left_q       <= '0;
		end else begin
			in_payload_q <= in_payload_d;
			hdr_cnt_q    <= hdr_cnt_d;
			cur_id_q     <= cur_id_d;
			cur_len_q    <= cur_len_d;
			left_q       <= left_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/lpfp_out_stage.sv @@
// ----------------------------------------------------------------------------
// lpfp_out_stage
// Result register with a skid entry, so the input side keeps taking bytes
// while a result waits on the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module lpfp_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire lpfp_pkg::result_t in_res,
	output logic                   in_ready,
	output logic                   out_valid,
	output lpfp_pkg::result_t      out_res,
	input  wire logic              out_ready
);
	import lpfp_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    pop;

	assign pop       = out_valid_q && out_ready;
	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_valid) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload: refill from skid first, then from the incoming request
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (in_valid) begin
			if (!out_valid_q || pop) begin
				out_q <= in_res;
			end else begin
				skid_q <= in_res;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/length_prefixed_frame_parser.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser
// Deframes a byte stream of messages with a 4-byte little-endian header
// (16-bit id, 16-bit payload length) into tagged payload bytes.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle while s_axis_tready is high and
// hands out at most one registered result per byte. Header bytes give no
// result, each payload byte gives one, and a zero-length message gives a
// single result with tuser set. Throughput is set by the parser state
// register, which updates once per byte; a result register backed by one
// skid entry lets bytes keep flowing while the output is stalled, and
// s_axis_tready drops only once both hold results. Setting s_axis_tuser on
// a request drops any partial frame and restarts at the header.
`default_nettype none

module length_prefixed_frame_parser (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [lpfp_pkg::BYTE_W-1:0]         s_axis_tdata,  // [7:0] rx_byte
	input  wire logic                                s_axis_tuser,  // [0] flush
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// [15:0] msg_id, [31:16] msg_len, [39:32] data_byte
	output logic [lpfp_pkg::TDATA_OUT_W-1:0]         m_axis_tdata,
	output logic                                     m_axis_tuser,  // [0] empty_msg
	output logic                                     m_axis_tlast
);
	import lpfp_pkg::*;

	logic    accept;
	logic    res_valid;
	result_t res;
	result_t out_res;

	assign accept = s_axis_tvalid && s_axis_tready;

	// Header and payload tracking
	lpfp_deframer u_deframer (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (s_axis_tdata),
		.flush     (s_axis_tuser),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register and skid
	lpfp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (res_valid),
		.in_res    (res),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_res   (out_res),
		.out_ready (m_axis_tready)
	);

	// Pack the result onto the master side
	assign m_axis_tdata = {out_res.data_byte, out_res.msg_len, out_res.msg_id};
	assign m_axis_tuser = out_res.empty_msg;
	assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

@@ hw/rtl/lpfp_checker.sv @@
// ----------------------------------------------------------------------------
// lpfp_checker
// Port-level checks of the length-prefixed frame parser, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "length_prefixed_frame_parser_macros.svh"

module lpfp_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	input  wire logic                                s_axis_tready,
	input  wire logic [lpfp_pkg::BYTE_W-1:0]         s_axis_tdata,
	input  wire logic                                s_axis_tuser,
	input  wire logic                                m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	input  wire logic [lpfp_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
	input  wire logic                                m_axis_tuser,
	input  wire logic                                m_axis_tlast
);
	import lpfp_pkg::*;

	logic stalled;
	logic in_seen;

	assign stalled = m_axis_tvalid && !m_axis_tready;
	assign in_seen = s_axis_tvalid || s_axis_tready || (|s_axis_tdata) || s_axis_tuser;

	// Hold a stalled result
	`LPFP_ASSERT_NEXT(a_out_hold, stalled,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")
	// An empty message is a single last result with zero data and length
	`LPFP_ASSERT(a_empty_last, !(m_axis_tvalid && m_axis_tuser) ||
		(m_axis_tlast && m_axis_tdata[39:16] == 24'd0), "empty result malformed")
	// A payload result always comes from a nonzero length
	`LPFP_ASSERT(a_payload_len, !(m_axis_tvalid && !m_axis_tuser) ||
		(m_axis_tdata[31:16] != 16'd0), "payload result with zero length")
	// Input side is not stalled while the output holds no result
	`LPFP_ASSERT_NEXT(a_skid_room, !m_axis_tvalid && in_seen, s_axis_tready,
		"ready dropped with output empty")

endmodule

bind length_prefixed_frame_parser lpfp_checker u_lpfp_checker (.*);

`default_nettype wire
